@@ rtl/core/edd_pkg.sv @@
// edd_pkg: shared types and fixed widths of the error diffusion dither
// holds the pixel and result transaction structs, the configuration bundle and register indexes
// no dependencies
package edd_pkg;

  // fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int QUANT_W     = 16;
  localparam int SCALE_W     = 32;
  localparam int OFFSET_W    = 32;
  localparam int BITS_W      = 5;
  localparam int LWIDTH_W    = 13;

  // fixed-point formats of the scale and offset registers
  localparam int SCALE_FRAC  = 24;
  localparam int OFFSET_FRAC = 16;

  // scaled sample plus offset, wide enough for every fraction width
  localparam int BASE_W      = 50;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCOUNT_W    = 3;

  // register port
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_SCALE      = 2'd0,
    REG_OFFSET     = 2'd1,
    REG_OUT_BITS   = 2'd2,
    REG_LINE_WIDTH = 2'd3
  } edd_reg_t;

  // input transaction
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_start;
  } edd_pixel_t;

  // output transaction
  typedef struct packed {
    logic [QUANT_W-1:0] quantized;
    logic               row_last;
  } edd_result_t;

  // configuration bundle
  typedef struct packed {
    logic [SCALE_W-1:0]  scale;
    logic [OFFSET_W-1:0] offset;
    logic [BITS_W-1:0]   out_bits;
    logic [LWIDTH_W-1:0] line_width;
  } edd_cfg_t;

endpackage

@@ rtl/core/edd_queue.sv @@
// edd_queue: short register queue between the front and back of the dither
// depends on edd_pkg for depth and pointer widths
module edd_queue import edd_pkg::*; #(
  parameter int DATA_W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [DATA_W-1:0]   wdata,
  input  logic                pop,
  output logic [DATA_W-1:0]   rdata,
  output logic                empty,
  output logic [QCOUNT_W-1:0] count
);

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCOUNT_W-1:0] count_next;

  // occupancy update
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCOUNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCOUNT_W'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  assign rdata = slots[rd_ptr];
  assign empty = (count == '0);

endmodule

@@ rtl/core/edd_front.sv @@
// edd_front: accepts pixels, tracks column and first row, scales the sample
// depends on edd_pkg; feeds edd_queue with one entry per pixel
module edd_front import edd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int FRAC_BITS = 16,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int ENTRY_W  = BASE_W + COL_W + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  edd_cfg_t            cfg,
  input  logic                pix_valid,
  output logic                pix_ready,
  input  edd_pixel_t          pix,
  input  logic [QCOUNT_W-1:0] q_count,
  output logic                push,
  output logic [ENTRY_W-1:0]  entry
);

  localparam int WID_W   = COL_W + 1;
  localparam int LW_CMP  = (WID_W > LWIDTH_W) ? WID_W : LWIDTH_W;
  localparam int PROD_W  = SAMPLE_W + SCALE_W;
  localparam int SH      = SCALE_FRAC - FRAC_BITS;
  localparam int OFF_UP  = (FRAC_BITS >= OFFSET_FRAC) ? FRAC_BITS - OFFSET_FRAC : 0;
  localparam int OFF_DN  = (FRAC_BITS < OFFSET_FRAC) ? OFFSET_FRAC - FRAC_BITS : 0;
  localparam int CRED_W  = QCOUNT_W + 1;
  localparam logic signed [BASE_W-1:0] RND = BASE_W'((1 << SH) >> 1);

  logic [COL_W-1:0]        column;
  logic                    first_row;

  logic [LW_CMP-1:0]       lw_ext;
  logic [WID_W-1:0]        width_eff;
  logic                    accept;
  logic [COL_W-1:0]        col0;
  logic                    fr0;
  logic [WID_W-1:0]        col_inc;
  logic                    last0;
  logic [CRED_W-1:0]       credit;

  logic                    f1_v;
  logic [SAMPLE_W-1:0]     f1_sample;
  logic [COL_W-1:0]        f1_col;
  logic                    f1_last;
  logic                    f1_fr;

  logic                    f2_v;
  logic [PROD_W-1:0]       f2_prod;
  logic [COL_W-1:0]        f2_col;
  logic                    f2_last;
  logic                    f2_fr;

  logic signed [BASE_W-1:0] off_ext;
  logic signed [BASE_W-1:0] off_al;
  logic signed [BASE_W-1:0] sum;
  logic signed [BASE_W-1:0] base;

  // effective row width, saturated to [1, MAX_WIDTH]
  always_comb begin
    lw_ext = LW_CMP'(cfg.line_width);
    priority if (lw_ext == '0) begin
      width_eff = WID_W'(1);
    end else if (lw_ext > LW_CMP'(MAX_WIDTH)) begin
      width_eff = WID_W'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext[WID_W-1:0];
    end
  end

  // room for every entry still in flight
  assign credit    = CRED_W'(q_count) + CRED_W'(f1_v) + CRED_W'(f2_v);
  assign pix_ready = (credit < CRED_W'(QUEUE_DEPTH));
  assign accept    = pix_valid && pix_ready;

  // column classification
  assign col0    = pix.frame_start ? '0 : column;
  assign fr0     = pix.frame_start || first_row;
  assign col_inc = WID_W'(col0) + WID_W'(1);
  assign last0   = (col_inc >= width_eff);

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      first_row <= 1'b1;
    end else if (accept) begin
      if (last0) begin
        column    <= '0;
        first_row <= 1'b0;
      end else begin
        column    <= col_inc[COL_W-1:0];
        first_row <= fr0;
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
    end else begin
      f1_v <= accept;
      f2_v <= f1_v;
    end
  end

  // sample stage and multiplier stage
  always_ff @(posedge clk) begin
    f1_sample <= pix.sample;
    f1_col    <= col0;
    f1_last   <= last0;
    f1_fr     <= fr0;
    f2_prod   <= PROD_W'(f1_sample) * PROD_W'(cfg.scale);
    f2_col    <= f1_col;
    f2_last   <= f1_last;
    f2_fr     <= f1_fr;
  end

  // round the product to the working fraction and add the aligned offset
  always_comb begin
    off_ext = BASE_W'($signed(cfg.offset));
    off_al  = ((off_ext <<< OFF_UP) >>> OFF_DN) <<< SH;
    sum     = $signed({2'b00, f2_prod}) + off_al + RND;
    base    = sum >>> SH;
  end

  assign push  = f2_v;
  assign entry = {base, f2_col, f2_last, f2_fr};

endmodule

@@ rtl/core/edd_back.sv @@
// edd_back: error line store, neighbour error gathering, quantiser loop
// depends on edd_pkg; takes entries from edd_queue, drives the result register
module edd_back import edd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int FRAC_BITS = 16,
  localparam int COL_W    = $clog2(MAX_WIDTH),
  localparam int ENTRY_W  = BASE_W + COL_W + 2
) (
  input  logic               clk,
  input  logic               rst,
  input  edd_cfg_t           cfg,
  input  logic               q_empty,
  input  logic [ENTRY_W-1:0] q_rdata,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output edd_result_t        res
);

  localparam int RES_W = FRAC_BITS + 2;
  localparam int P_W   = RES_W + 5;
  localparam int KL_W  = RES_W + 5;
  localparam int Y_W   = BASE_W + 5;
  localparam int X_W   = BASE_W + 1;
  localparam int Q_W   = QUANT_W + FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

  // queue head fields
  logic signed [BASE_W-1:0] q_base;
  logic [COL_W-1:0]         q_col;
  logic                     q_last;
  logic                     q_fr;
  logic [COL_W-1:0]         q_col_nx;

  logic                     adv;
  logic                     wr_en;

  // error line store
  logic signed [RES_W-1:0]  line_mem [MAX_WIDTH];

  // read stage
  logic                     rd_v;
  logic signed [BASE_W-1:0] rd_base;
  logic [COL_W-1:0]         rd_col;
  logic                     rd_last;
  logic                     rd_fr;
  logic signed [RES_W-1:0]  rd_up;
  logic signed [RES_W-1:0]  rd_ur;

  // last write to the store
  logic                     h_v;
  logic [COL_W-1:0]         h_col;
  logic signed [RES_W-1:0]  h_res;

  // loop stage
  logic                     lp_v;
  logic signed [Y_W-1:0]    lp_b16;
  logic [3:0]               lp_k;
  logic [COL_W-1:0]         lp_col;
  logic                     lp_last;
  logic signed [RES_W-1:0]  lp_up;
  logic                     lp_upl;

  // loop state
  logic signed [RES_W-1:0]  left;
  logic signed [RES_W-1:0]  prev_up;

  // gathering
  logic [COL_W-1:0]         rd_col_nx;
  logic signed [RES_W-1:0]  up_mem;
  logic signed [RES_W-1:0]  ur_mem;
  logic                     upl;
  logic                     url;
  logic signed [RES_W-1:0]  up_v;
  logic signed [RES_W-1:0]  ur_v;
  logic signed [RES_W-1:0]  ul_src;
  logic signed [RES_W-1:0]  ul_v;
  logic signed [P_W-1:0]    psum;
  logic [3:0]               kc;
  logic signed [Y_W-1:0]    b16;

  // quantiser
  logic signed [KL_W-1:0]   kl;
  logic signed [Y_W-1:0]    y;
  logic signed [X_W-1:0]    x;
  logic [BITS_W-1:0]        bits_c;
  logic [QUANT_W:0]         ceil_w;
  logic [Q_W-1:0]           hi;
  logic [Q_W-1:0]           x_cl;
  logic [QUANT_W-1:0]       q0;
  logic [FRAC_BITS-1:0]     frac;
  logic                     inc;
  logic [QUANT_W-1:0]       qv;
  logic signed [RES_W-1:0]  lp_res;

  // the whole back part moves when the result register can take a value
  assign adv   = !res_valid || res_ready;
  assign q_pop = adv && !q_empty;
  assign wr_en = adv && lp_v;

  assign {q_base, q_col, q_last, q_fr} = q_rdata;
  assign q_col_nx = q_col + COL_W'(1);

  // store: read upper and upper-right entries, write the residue
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_up <= line_mem[q_col];
      rd_ur <= line_mem[q_col_nx];
    end
    if (wr_en) begin
      line_mem[lp_col] <= lp_res;
    end
  end

  // valid bits and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      lp_v      <= 1'b0;
      res_valid <= 1'b0;
      h_v       <= 1'b0;
      left      <= '0;
      prev_up   <= '0;
    end else begin
      if (adv) begin
        rd_v      <= !q_empty;
        lp_v      <= rd_v;
        res_valid <= lp_v;
      end
      if (wr_en) begin
        h_v     <= 1'b1;
        left    <= lp_res;
        prev_up <= lp_upl ? left : lp_up;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_base <= q_base;
      rd_col  <= q_col;
      rd_last <= q_last;
      rd_fr   <= q_fr;
      lp_b16  <= b16;
      lp_k    <= kc;
      lp_col  <= rd_col;
      lp_last <= rd_last;
      lp_up   <= up_v;
      lp_upl  <= upl;
      res.quantized <= qv;
      res.row_last  <= lp_last;
    end
    if (wr_en) begin
      h_col <= lp_col;
      h_res <= lp_res;
    end
  end

  // neighbour errors: the pixel in the loop stage is forwarded through left,
  // the write just made through the last-write register
  always_comb begin
    rd_col_nx = rd_col + COL_W'(1);
    up_mem = (h_v && h_col == rd_col) ? h_res : rd_up;
    ur_mem = (h_v && h_col == rd_col_nx) ? h_res : rd_ur;
    upl    = !rd_fr && lp_v && (lp_col == rd_col);
    url    = !rd_fr && !rd_last && lp_v && (lp_col == rd_col_nx);
    up_v   = (rd_fr || upl) ? '0 : up_mem;
    ur_v   = (rd_fr || rd_last || url) ? '0 : ur_mem;
    ul_src = lp_v ? (lp_upl ? left : lp_up) : prev_up;
    ul_v   = (rd_col == '0) ? '0 : ul_src;
    psum   = (P_W'(ur_v) <<< 1) + P_W'(ur_v) + (P_W'(up_v) <<< 2) + P_W'(up_v)
           + P_W'(ul_v) + P_W'(8);
    kc     = ((rd_col != '0) ? 4'd7 : 4'd0) + (upl ? 4'd5 : 4'd0) + (url ? 4'd3 : 4'd0);
    b16    = (Y_W'(rd_base) <<< 4) + Y_W'(psum);
  end

  // output depth saturated to [1, 16]
  always_comb begin
    priority if (cfg.out_bits == '0) begin
      bits_c = BITS_W'(1);
    end else if (cfg.out_bits > BITS_W'(QUANT_W)) begin
      bits_c = BITS_W'(QUANT_W);
    end else begin
      bits_c = cfg.out_bits;
    end
    ceil_w = ((QUANT_W+1)'(1) << bits_c) - (QUANT_W+1)'(1);
    hi     = {ceil_w[QUANT_W-1:0], {FRAC_BITS{1'b0}}};
  end

  // left-error loop: add, clamp, round to nearest even, residue
  always_comb begin
    kl = $signed({1'b0, lp_k}) * KL_W'(left);
    y  = lp_b16 + Y_W'(kl);
    x  = $signed(y[Y_W-1:4]);
    priority if (x < 0) begin
      x_cl = '0;
    end else if (x > $signed(X_W'(hi))) begin
      x_cl = hi;
    end else begin
      x_cl = x[Q_W-1:0];
    end
    q0     = x_cl[Q_W-1:FRAC_BITS];
    frac   = x_cl[FRAC_BITS-1:0];
    inc    = (frac > HALF) || ((frac == HALF) && q0[0]);
    qv     = q0 + QUANT_W'(inc);
    lp_res = $signed({2'b00, frac}) - $signed({1'b0, inc, {FRAC_BITS{1'b0}}});
  end

endmodule

@@ rtl/core/error_diffusion_dither.sv @@
// error_diffusion_dither: top level of the floyd-steinberg error diffusion dither
// holds the register port and joins edd_front, edd_queue and edd_back
// depends on edd_pkg
//
//   channel   signals                             transaction
//   pix       pix_valid, pix_ready, pix           one source pixel in raster order
//   res       res_valid, res_ready, res           one dithered pixel
//   regs      psel, penable, pwrite, paddr, ...   register write or read
//
// one pixel per clock sustained while results are taken; a result passes through
// the two front stages (sample, 16x32 multiply), the queue, the store read
// and the left-error loop of add, clamp and round.
// synchronous reset clears control state; the error line store has no clearing pass.
// a stalled result holds the back part; the front keeps taking pixels until four
// are held in its two stages and the four-entry queue together.
module error_diffusion_dither import edd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  edd_pixel_t         pix,
  output logic               res_valid,
  input  logic               res_ready,
  output edd_result_t        res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ENTRY_W = BASE_W + COL_W + 2;

  localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(32'h0100_0000);
  localparam logic [BITS_W-1:0]   BITS_RST   = BITS_W'(8);
  localparam logic [LWIDTH_W-1:0] LWIDTH_RST = LWIDTH_W'(4096);

  edd_cfg_t           cfg;
  edd_reg_t           reg_sel;
  logic               reg_wr;
  logic               push;
  logic [ENTRY_W-1:0] entry;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_rdata;
  logic               q_empty;
  logic [QCOUNT_W-1:0] q_count;

  assign pready  = 1'b1;
  assign reg_sel = edd_reg_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale      <= SCALE_RST;
      cfg.offset     <= '0;
      cfg.out_bits   <= BITS_RST;
      cfg.line_width <= LWIDTH_RST;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_SCALE: begin
          cfg.scale <= pwdata[SCALE_W-1:0];
        end
        REG_OFFSET: begin
          cfg.offset <= pwdata[OFFSET_W-1:0];
        end
        REG_OUT_BITS: begin
          cfg.out_bits <= pwdata[BITS_W-1:0];
        end
        REG_LINE_WIDTH: begin
          cfg.line_width <= pwdata[LWIDTH_W-1:0];
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_sel)
      REG_SCALE: begin
        prdata = PDATA_W'(cfg.scale);
      end
      REG_OFFSET: begin
        prdata = PDATA_W'(cfg.offset);
      end
      REG_OUT_BITS: begin
        prdata = PDATA_W'(cfg.out_bits);
      end
      REG_LINE_WIDTH: begin
        prdata = PDATA_W'(cfg.line_width);
      end
    endcase
  end

  // pixel intake and scaling
  edd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .q_count   (q_count),
    .push      (push),
    .entry     (entry)
  );

  // decoupling queue
  edd_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  // error diffusion and quantiser
  edd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench of the error diffusion dither top level
// carries its own dithering predictor in a small scoreboard class, drives pixels,
// register writes from plain tasks, result back-pressure from an always block; depends on edd_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import edd_pkg::*;

  localparam int MAX_W           = 4096;
  localparam int FRAC_Q          = 16;
  localparam int IDLE_PCT        = 22;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int SETTLE_CYCLES   = 8;

  // predicts dithered pixels and checks the results against them
  class dither_scoreboard;
    logic [SCALE_W-1:0]  scale_q;
    logic [OFFSET_W-1:0] offset_q;
    logic [BITS_W-1:0]   out_bits;
    logic [LWIDTH_W-1:0] line_width;
    int                  residue_line [MAX_W];
    int                  left_res;
    int                  upper_left_res;
    int unsigned         column;
    bit                  first_row;
    edd_result_t         expected_pixels [$];
    int                  mismatches;

    function new();
      scale_q        = 32'h0100_0000;
      offset_q       = '0;
      out_bits       = 5'd8;
      line_width     = 13'd4096;
      foreach (residue_line[i]) residue_line[i] = 0;
      left_res       = 0;
      upper_left_res = 0;
      column         = 0;
      first_row      = 1'b1;
      mismatches     = 0;
    endfunction

    function void apply_register(edd_reg_t idx, logic [31:0] value);
      case (idx)
        REG_SCALE:      scale_q    = value;
        REG_OFFSET:     offset_q   = value;
        REG_OUT_BITS:   out_bits   = value[BITS_W-1:0];
        REG_LINE_WIDTH: line_width = value[LWIDTH_W-1:0];
        default: ;
      endcase
    endfunction

    // one pixel through scale, offset, error diffusion, clamp and round
    function edd_result_t dither_pixel(edd_pixel_t px);
      int unsigned depth;
      int unsigned w;
      int unsigned c;
      longint      left_e, ul_e, up_e, ur_e, err;
      longint      prod, scaled, x, hi, frac, half, q, resid;
      bit          last;
      edd_result_t r;
      depth = (out_bits < 1) ? 1 : (out_bits > 16) ? 16 : out_bits;
      w = (line_width < 1) ? 1 : (line_width > MAX_W) ? MAX_W : line_width;
      if (px.frame_start) begin
        column    = 0;
        first_row = 1'b1;
      end
      c = (column >= MAX_W) ? MAX_W - 1 : column;

      // neighbour residues, zero at the row edges and in the first row
      left_e = (c == 0) ? 0 : left_res;
      ul_e   = (c == 0) ? 0 : upper_left_res;
      if (first_row) begin
        up_e = 0;
        ur_e = 0;
      end else begin
        up_e = residue_line[c];
        ur_e = (c + 1 < w) ? residue_line[c + 1] : 0;
      end
      err = (7 * left_e + 3 * ur_e + 5 * up_e + ul_e + 8) >>> 4;

      // scale rounds half up from Q8.24; offset already sits at 16 fraction bits
      prod   = longint'(px.sample) * longint'(scale_q);
      scaled = (prod + (longint'(1) << (SCALE_FRAC - FRAC_Q - 1))) >>> (SCALE_FRAC - FRAC_Q);
      x      = scaled + (longint'($signed(offset_q)) <<< (FRAC_Q - OFFSET_FRAC)) + err;

      hi = ((longint'(1) << depth) - 1) << FRAC_Q;
      if (x < 0) x = 0;
      if (x > hi) x = hi;

      // round to nearest, ties to even
      q    = x >>> FRAC_Q;
      frac = x & ((longint'(1) << FRAC_Q) - 1);
      half = longint'(1) << (FRAC_Q - 1);
      if (frac > half || (frac == half && q[0])) q = q + 1;
      resid = x - (q <<< FRAC_Q);

      residue_line[c] = int'(resid);
      left_res        = int'(resid);
      upper_left_res  = int'(up_e);

      last = (c + 1 >= w);
      if (last) begin
        column    = 0;
        first_row = 1'b0;
      end else begin
        column = c + 1;
      end
      r.quantized = q[QUANT_W-1:0];
      r.row_last  = last;
      return r;
    endfunction

    function void note_pixel(edd_pixel_t px);
      expected_pixels.push_back(dither_pixel(px));
    endfunction

    function void check_result(edd_result_t got);
      edd_result_t want;
      if (expected_pixels.size() == 0) begin
        if (mismatches < 10)
          $display("result with none outstanding: quantized %0d row_last %0b",
                   got.quantized, got.row_last);
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.quantized !== want.quantized || got.row_last !== want.row_last) begin
        if (mismatches < 10)
          $display("result mismatch: quantized exp %0d got %0d, row_last exp %0b got %0b",
                   want.quantized, got.quantized, want.row_last, got.row_last);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                pix_valid = 1'b0;
  logic                pix_ready;
  edd_pixel_t          pix       = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  edd_result_t         res;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  dither_scoreboard    sb;
  bit                  src_gaps    = 1'b1;
  bit                  sink_gaps   = 1'b1;
  int                  sink_hold   = 0;
  bit                  force_frame = 1'b0;
  int unsigned         width_eff   = MAX_W;
  int unsigned         cycle_count = 0;

  error_diffusion_dither #(
    .MAX_WIDTH(MAX_W),
    .FRAC_BITS(FRAC_Q)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result back-pressure, with an occasional long hold-off
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      res_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      res_ready <= !(sink_gaps && $urandom_range(99) < IDLE_PCT);
    end
  end

  // note each accepted pixel, check each accepted result
  always @(posedge clk) begin
    if (!rst && pix_valid && pix_ready) sb.note_pixel(pix);
    if (!rst && res_valid && res_ready) sb.check_result(res);
  end

  // offer one pixel and hold it until the transaction completes
  task automatic send_pixel(input logic [SAMPLE_W-1:0] sample, input bit frame_start);
    edd_pixel_t p;
    while (src_gaps && $urandom_range(99) < IDLE_PCT) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    if (force_frame) begin
      frame_start = 1'b1;
      force_frame = 1'b0;
    end
    p.sample      = sample;
    p.frame_start = frame_start;
    pix_valid <= 1'b1;
    pix       <= p;
    do @(posedge clk); while (!pix_ready);
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_for_results();
    pix_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup then access cycle; a wider row restarts the frame
  task automatic write_register(input edd_reg_t idx, input logic [31:0] value);
    int unsigned new_eff;
    if (idx == REG_LINE_WIDTH) begin
      new_eff = (value[LWIDTH_W-1:0] == 0) ? 1 :
                (value[LWIDTH_W-1:0] > MAX_W) ? MAX_W : value[LWIDTH_W-1:0];
      if (new_eff > width_eff) force_frame = 1'b1;
      width_eff = new_eff;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.apply_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] scale_v, input logic [31:0] offset_v,
                           input logic [31:0] bits_v, input logic [31:0] width_v);
    wait_for_results();
    write_register(REG_SCALE, scale_v);
    write_register(REG_OFFSET, offset_v);
    write_register(REG_OUT_BITS, bits_v);
    write_register(REG_LINE_WIDTH, width_v);
  endtask

  initial begin
    int unsigned eff_bits;
    int unsigned n_items;
    logic [31:0] scale_v, offset_v, bits_v, width_v;
    logic [15:0] sample_v;

    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: half offset makes the first pixel a rounding tie
    configure(32'h0100_0000, 32'h0000_8000, 32'd8, 32'd6);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hffff, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h7fff, 1'b0);
    send_pixel(16'hffff, 1'b0);
    // second row reads the upper residues
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hffff, 1'b0);
    send_pixel(16'h0080, 1'b0);
    send_pixel(16'h00c8, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'haaaa, 1'b0);

    // depth outside its range saturates at both ends
    wait_for_results();
    write_register(REG_OUT_BITS, 32'd0);
    send_pixel(16'h7fff, 1'b0);
    send_pixel(16'h8001, 1'b0);
    wait_for_results();
    write_register(REG_OUT_BITS, 32'd31);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'hfedc, 1'b0);

    // row shrunk to two pixels, then width zero and oversized
    wait_for_results();
    write_register(REG_OUT_BITS, 32'd8);
    send_pixel(16'h0101, 1'b0);
    send_pixel(16'h0202, 1'b0);
    wait_for_results();
    write_register(REG_LINE_WIDTH, 32'd2);
    send_pixel(16'h0303, 1'b0);
    send_pixel(16'h0404, 1'b0);
    wait_for_results();
    write_register(REG_LINE_WIDTH, 32'd0);
    send_pixel(16'h4000, 1'b0);
    send_pixel(16'hc000, 1'b0);
    wait_for_results();
    write_register(REG_LINE_WIDTH, 32'd8191);
    send_pixel(16'h2222, 1'b0);
    send_pixel(16'hdddd, 1'b0);

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(9))
        0:       bits_v = 32'd0;
        1:       bits_v = $urandom_range(17, 31);
        2:       bits_v = 32'd1;
        3:       bits_v = 32'd16;
        default: bits_v = $urandom_range(1, 16);
      endcase
      eff_bits = (bits_v < 1) ? 1 : (bits_v > 16) ? 16 : bits_v;
      case ($urandom_range(7))
        0:       scale_v = 32'h0000_0000;
        1:       scale_v = 32'hffff_ffff;
        2:       scale_v = $urandom;
        default: scale_v = (32'h0100_0000 >> (16 - eff_bits)) ^ $urandom_range(0, 255);
      endcase
      case ($urandom_range(7))
        0:       offset_v = 32'h8000_0000;
        1:       offset_v = 32'h7fff_ffff;
        2:       offset_v = $urandom;
        3:       offset_v = 32'h0000_0000;
        default: offset_v = $urandom_range(0, 32'h0001_ffff) - 32'h0001_0000;
      endcase
      case ($urandom_range(19))
        0:          width_v = 32'd0;
        1:          width_v = 32'd8191;
        2:          width_v = 32'd4096;
        3, 4, 5:    width_v = $urandom_range(17, 64);
        default:    width_v = $urandom_range(1, 16);
      endcase
      if (ph == 0) begin
        scale_v  = 32'hffff_ffff;
        offset_v = 32'h8000_0000;
      end
      if (ph == 1) begin
        scale_v  = 32'h0000_0000;
        offset_v = 32'h7fff_ffff;
      end
      configure(scale_v, offset_v, bits_v, width_v);

      // one phase with a long result hold-off, one with no idling at all
      src_gaps  = (ph != 3 && ph != 5);
      sink_gaps = (ph != 5);
      if (ph == 3) sink_hold = HOLD_OFF_CYCLES;

      n_items = (width_eff >= 1024) ? 20 : 46;
      for (int i = 0; i < n_items; i++) begin
        case ($urandom_range(19))
          0:          sample_v = 16'h0000;
          1:          sample_v = 16'hffff;
          2, 3, 4, 5: sample_v = $urandom_range(0, 255);
          default:    sample_v = $urandom_range(0, 16'hffff);
        endcase
        send_pixel(sample_v, ($urandom_range(99) < 3));
      end
    end

    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    wait_for_results();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/edd_pkg.sv
rtl/core/edd_queue.sv
rtl/core/edd_front.sv
rtl/core/edd_back.sv
rtl/core/error_diffusion_dither.sv
verif/tb_top.sv
